FILE: rtl/isr_pkg.sv
// shared widths, codes and the configuration record of the ising ring spin update block
package isr_pkg;

    // default ring storage depth
    localparam int MAX_SPINS_DEF = 1024;

    // field widths
    localparam int MODE_W    = 2;
    localparam int SITE_W    = 10;
    localparam int RING_W    = 11;
    localparam int THR_W     = 17;
    localparam int RND_W     = 16;
    localparam int MEAS_W    = 12;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_THR   = 6;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    // register indexes, thresholds follow the base in order
    localparam logic [CFG_IDX_W-1:0] CFG_RULE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_BASE = 3'd2;

    // update rules
    localparam logic RULE_METROPOLIS = 1'b0;
    localparam logic RULE_GIBBS      = 1'b1;

    // reset values
    localparam logic [RING_W-1:0] RING_LEN_RST = 11'd1024;
    localparam logic [THR_W-1:0]  THR_ONE      = 17'h10000;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic                             rule;
        logic [RING_W-1:0]                ring_length;
        logic [NUM_THR-1:0][THR_W-1:0]    thr;
    } t_cfg;

endpackage

FILE: rtl/isr_ram.sv
// generic single write port, single read port ram with registered read data
module isr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = isr_pkg::MAX_SPINS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/isr_cfg.sv
// configuration register file: rule, ring length and six update thresholds
module isr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [isr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [isr_pkg::THR_W-1:0]        i_cfg_data,
    output isr_pkg::t_cfg                    o_cfg
);
    import isr_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [CFG_IDX_W-1:0] thr_idx;

    // threshold slot from register index
    assign thr_idx = i_cfg_index - CFG_THR_BASE;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RULE:     n_cfg.rule        = i_cfg_data[0];
                CFG_RING_LEN: n_cfg.ring_length = i_cfg_data[RING_W-1:0];
                default:      n_cfg.thr[thr_idx] = i_cfg_data;
            endcase
        end
    end

    // register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rule        <= RULE_METROPOLIS;
            r_cfg.ring_length <= RING_LEN_RST;
            r_cfg.thr         <= {NUM_THR{THR_ONE}};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

FILE: rtl/isr_core.sv
// spin ring sequencer: clearing pass, load, update and measure over the spin ram, and a counter clear
module isr_core #(
    parameter int MAX_SPINS = isr_pkg::MAX_SPINS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  isr_pkg::t_cfg               i_cfg,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [isr_pkg::MODE_W-1:0]  i_mode,
    input  logic [isr_pkg::SITE_W-1:0]  i_site,
    input  logic                        i_spin_value,
    input  logic [isr_pkg::RND_W-1:0]   i_random_u,
    output logic                        o_done,
    output logic                        o_new_spin,
    output logic                        o_changed,
    output logic [isr_pkg::MEAS_W-1:0]  o_magnetization,
    output logic [isr_pkg::MEAS_W-1:0]  o_bond_sum,
    output logic [isr_pkg::CNT_W-1:0]   o_accepted_count,
    output logic [isr_pkg::CNT_W-1:0]   o_attempted_count,
    output logic                        o_bad_site
);
    import isr_pkg::*;

    localparam int AW     = $clog2(MAX_SPINS);
    localparam int LEN_CW = $clog2(MAX_SPINS + 1);
    localparam int LEN_W  = (LEN_CW > RING_W) ? LEN_CW : RING_W;

    // sequencer states
    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_UPD_L = 3'd3;
    localparam logic [2:0] ST_UPD_R = 3'd4;
    localparam logic [2:0] ST_UPD_S = 3'd5;
    localparam logic [2:0] ST_MEAS  = 3'd6;

    localparam logic [MEAS_W-1:0] M_PLUS  = MEAS_W'(1);
    localparam logic [MEAS_W-1:0] M_MINUS = {MEAS_W{1'b1}};

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [LEN_W-1:0]  r_site, n_site;
    logic              r_val, n_val;
    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic              r_left, n_left;
    logic              r_right, n_right;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [MEAS_W-1:0] r_mag, n_mag;
    logic [MEAS_W-1:0] r_bond, n_bond;
    logic              r_first, n_first;
    logic              r_prev, n_prev;
    logic [CNT_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_att, n_att;
    logic              r_done, n_done;
    logic              r_new_spin, n_new_spin;
    logic              r_changed, n_changed;
    logic [MEAS_W-1:0] r_mag_out, n_mag_out;
    logic [MEAS_W-1:0] r_bond_out, n_bond_out;
    logic              r_bad, n_bad;

    logic [LEN_W-1:0]  ring_ext;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  site_src;
    logic [LEN_W-1:0]  site_inc;
    logic [LEN_W-1:0]  left_idx;
    logic [LEN_W-1:0]  right_idx;
    logic              accept;
    logic              bad_in;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic              ram_rdata;

    logic [2:0]        thr_sel;
    logic [THR_W-1:0]  thr;
    logic              thr_ge;
    logic              thr_gt;
    logic              metro;
    logic              next_spin;

    logic [LEN_W-1:0]  meas_next;
    logic              meas_last;
    logic              first;
    logic [MEAS_W-1:0] mag_step;
    logic [MEAS_W-1:0] bond_step;
    logic [MEAS_W-1:0] bond_final;

    // spin storage
    isr_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SPINS)
    ) u_spins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective ring length, clamped to [2, MAX_SPINS]
    assign ring_ext = LEN_W'(i_cfg.ring_length);
    always_comb begin
        if (ring_ext < LEN_W'(2)) begin
            eff_len = LEN_W'(2);
        end else if (ring_ext > LEN_W'(MAX_SPINS)) begin
            eff_len = LEN_W'(MAX_SPINS);
        end else begin
            eff_len = ring_ext;
        end
    end

    // neighbour addresses around the ring
    assign site_src  = (r_state == ST_IDLE) ? LEN_W'(i_site) : r_site;
    assign site_inc  = site_src + LEN_W'(1);
    assign left_idx  = (site_src == '0) ? eff_len - LEN_W'(1) : site_src - LEN_W'(1);
    assign right_idx = (site_inc == eff_len) ? '0 : site_inc;

    // handshake and site range check
    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;
    assign bad_in = ((i_mode == MODE_LOAD) || (i_mode == MODE_UPDATE))
                    && (LEN_W'(i_site) >= eff_len);

    // threshold select and acceptance test
    assign thr_sel   = (ram_rdata ? 3'd0 : 3'd3) + {2'b00, r_left} + {2'b00, r_right};
    assign thr       = i_cfg.thr[thr_sel];
    assign thr_ge    = thr >= {1'b0, r_rnd};
    assign thr_gt    = thr > {1'b0, r_rnd};
    assign metro     = (i_cfg.rule == RULE_METROPOLIS);
    assign next_spin = metro ? (thr_ge ? ~ram_rdata : ram_rdata) : thr_gt;

    // ring walk accumulation
    assign meas_next  = r_pos + LEN_W'(1);
    assign meas_last  = (r_pos == eff_len - LEN_W'(1));
    assign first      = (r_pos == '0) ? ram_rdata : r_first;
    assign mag_step   = r_mag + (ram_rdata ? M_PLUS : M_MINUS);
    assign bond_step  = (r_pos == '0) ? r_bond
                        : r_bond + ((ram_rdata == r_prev) ? M_PLUS : M_MINUS);
    assign bond_final = bond_step + ((ram_rdata == first) ? M_PLUS : M_MINUS);

    // sequencer next state and datapath
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_site     = r_site;
        n_val      = r_val;
        n_rnd      = r_rnd;
        n_left     = r_left;
        n_right    = r_right;
        n_pos      = r_pos;
        n_mag      = r_mag;
        n_bond     = r_bond;
        n_first    = r_first;
        n_prev     = r_prev;
        n_acc      = r_acc;
        n_att      = r_att;
        n_done     = 1'b0;
        n_new_spin = r_new_spin;
        n_changed  = r_changed;
        n_mag_out  = r_mag_out;
        n_bond_out = r_bond_out;
        n_bad      = r_bad;
        ram_we     = 1'b0;
        ram_waddr  = r_site[AW-1:0];
        ram_wdata  = r_val;
        ram_raddr  = site_src[AW-1:0];

        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 1'b1;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(MAX_SPINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_site = LEN_W'(i_site);
                    n_val  = i_spin_value;
                    n_rnd  = i_random_u;
                    if (bad_in) begin
                        n_done     = 1'b1;
                        n_new_spin = 1'b0;
                        n_changed  = 1'b0;
                        n_mag_out  = '0;
                        n_bond_out = '0;
                        n_bad      = 1'b1;
                    end else begin
                        case (i_mode)
                            MODE_LOAD: begin
                                n_state = ST_LOAD;
                            end
                            MODE_UPDATE: begin
                                ram_raddr = left_idx[AW-1:0];
                                n_state   = ST_UPD_L;
                            end
                            MODE_MEASURE: begin
                                ram_raddr = '0;
                                n_pos     = '0;
                                n_mag     = '0;
                                n_bond    = '0;
                                n_state   = ST_MEAS;
                            end
                            default: begin
                                n_acc      = '0;
                                n_att      = '0;
                                n_done     = 1'b1;
                                n_new_spin = 1'b0;
                                n_changed  = 1'b0;
                                n_mag_out  = '0;
                                n_bond_out = '0;
                                n_bad      = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_LOAD: begin
                ram_we     = 1'b1;
                ram_wdata  = r_val;
                n_done     = 1'b1;
                n_new_spin = r_val;
                n_changed  = (ram_rdata != r_val);
                n_mag_out  = '0;
                n_bond_out = '0;
                n_bad      = 1'b0;
                n_state    = ST_IDLE;
            end
            ST_UPD_L: begin
                n_left    = ram_rdata;
                ram_raddr = right_idx[AW-1:0];
                n_state   = ST_UPD_R;
            end
            ST_UPD_R: begin
                n_right   = ram_rdata;
                ram_raddr = r_site[AW-1:0];
                n_state   = ST_UPD_S;
            end
            ST_UPD_S: begin
                ram_we    = 1'b1;
                ram_wdata = next_spin;
                if (metro) begin
                    n_att = sat_inc(r_att);
                    if (thr_ge) begin
                        n_acc = sat_inc(r_acc);
                    end
                end
                n_done     = 1'b1;
                n_new_spin = next_spin;
                n_changed  = (next_spin != ram_rdata);
                n_mag_out  = '0;
                n_bond_out = '0;
                n_bad      = 1'b0;
                n_state    = ST_IDLE;
            end
            ST_MEAS: begin
                ram_raddr = meas_next[AW-1:0];
                n_pos     = meas_next;
                n_mag     = mag_step;
                n_bond    = bond_step;
                n_first   = first;
                n_prev    = ram_rdata;
                if (meas_last) begin
                    n_done     = 1'b1;
                    n_new_spin = 1'b0;
                    n_changed  = 1'b0;
                    n_mag_out  = mag_step;
                    n_bond_out = bond_final;
                    n_bad      = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr   <= '0;
            r_acc   <= '0;
            r_att   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_acc   <= n_acc;
            r_att   <= n_att;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_site     <= n_site;
        r_val      <= n_val;
        r_rnd      <= n_rnd;
        r_left     <= n_left;
        r_right    <= n_right;
        r_pos      <= n_pos;
        r_mag      <= n_mag;
        r_bond     <= n_bond;
        r_first    <= n_first;
        r_prev     <= n_prev;
        r_new_spin <= n_new_spin;
        r_changed  <= n_changed;
        r_mag_out  <= n_mag_out;
        r_bond_out <= n_bond_out;
        r_bad      <= n_bad;
    end

    assign o_done            = r_done;
    assign o_new_spin        = r_new_spin;
    assign o_changed         = r_changed;
    assign o_magnetization   = r_mag_out;
    assign o_bond_sum        = r_bond_out;
    assign o_accepted_count  = r_acc;
    assign o_attempted_count = r_att;
    assign o_bad_site        = r_bad;

`ifndef SYNTHESIS
    // accepted flips never outnumber attempts
    a_acc_le_att: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= r_att)
        else $error("accepted count above attempted count");

    // the ring walk never writes the spin ram
    a_meas_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MEAS) |-> !ram_we)
        else $error("spin ram written during measure");

    // an accepted item either keeps the block busy or reports at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_busy || o_done))
        else $error("accepted item neither busy nor reported");

    // a bad site report carries no spin change
    a_bad_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_site) |-> (!o_new_spin && !o_changed))
        else $error("bad site result shows a spin");
`endif

endmodule

FILE: rtl/ising_ring_spin_update_top.sv
// top level of the ising ring spin update block: configuration registers and spin sequencer
//
// channel   direction  handshake                      payload
// -------   ---------  -----------------------------  ------------------------------------------
// item      in         start high while busy low      i_mode, i_site, i_spin_value, i_random_u
// result    out        o_done high for one cycle      o_new_spin, o_changed, o_magnetization,
//                                                     o_bond_sum, o_accepted_count,
//                                                     o_attempted_count, o_bad_site
// config    in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// per beat: load writes the spin; update reads left, right and own spin one after the other
// through the single ram read port, then writes the new spin; measure walks the ring with its
// length clamped to [2, MAX_SPINS] (one spin read per cycle); clear and bad site report from
// idle. the result strobe comes in the cycle after the last step.
// after reset a clearing pass writes every spin up with busy high;
// configuration writes are taken throughout.
// the receiver cannot stall: each result is shown for exactly one cycle.
module ising_ring_spin_update_top #(
    parameter int MAX_SPINS = isr_pkg::MAX_SPINS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [isr_pkg::MODE_W-1:0]         i_mode,
    input  logic [isr_pkg::SITE_W-1:0]         i_site,
    input  logic                               i_spin_value,
    input  logic [isr_pkg::RND_W-1:0]          i_random_u,
    output logic                               o_done,
    output logic                               o_new_spin,
    output logic                               o_changed,
    output logic signed [isr_pkg::MEAS_W-1:0]  o_magnetization,
    output logic signed [isr_pkg::MEAS_W-1:0]  o_bond_sum,
    output logic [isr_pkg::CNT_W-1:0]          o_accepted_count,
    output logic [isr_pkg::CNT_W-1:0]          o_attempted_count,
    output logic                               o_bad_site,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [isr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [isr_pkg::THR_W-1:0]          i_cfg_data
);
    import isr_pkg::*;

    t_cfg              cfg;
    logic [MEAS_W-1:0] mag;
    logic [MEAS_W-1:0] bond;

    // configuration registers
    isr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // spin ring sequencer with its ram
    isr_core #(
        .MAX_SPINS (MAX_SPINS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_start           (start),
        .o_busy            (busy),
        .i_mode            (i_mode),
        .i_site            (i_site),
        .i_spin_value      (i_spin_value),
        .i_random_u        (i_random_u),
        .o_done            (o_done),
        .o_new_spin        (o_new_spin),
        .o_changed         (o_changed),
        .o_magnetization   (mag),
        .o_bond_sum        (bond),
        .o_accepted_count  (o_accepted_count),
        .o_attempted_count (o_attempted_count),
        .o_bad_site        (o_bad_site)
    );

    // signed view of the measure sums
    assign o_magnetization = $signed(mag);
    assign o_bond_sum      = $signed(bond);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the ising ring spin update block
module tb;
    import isr_pkg::*;

    localparam int RING_DEPTH   = MAX_SPINS_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    // longest walk of a measure over the full ring plus margin
    localparam int DRAIN_CYCLES = RING_DEPTH + 16;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 60;

    // one result beat as predicted
    typedef struct packed {
        logic              new_spin;
        logic              changed;
        logic [MEAS_W-1:0] magnetization;
        logic [MEAS_W-1:0] bond_sum;
        logic [CNT_W-1:0]  accepted_count;
        logic [CNT_W-1:0]  attempted_count;
        logic              bad_site;
    } t_spin_result;

    // dut ports
    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     start        = 1'b0;
    logic                     busy;
    logic [MODE_W-1:0]        i_mode       = MODE_LOAD;
    logic [SITE_W-1:0]        i_site       = '0;
    logic                     i_spin_value = 1'b0;
    logic [RND_W-1:0]         i_random_u   = '0;
    logic                     o_done;
    logic                     o_new_spin;
    logic                     o_changed;
    logic signed [MEAS_W-1:0] o_magnetization;
    logic signed [MEAS_W-1:0] o_bond_sum;
    logic [CNT_W-1:0]         o_accepted_count;
    logic [CNT_W-1:0]         o_attempted_count;
    logic                     o_bad_site;
    logic                     i_cfg_valid  = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index  = CFG_RULE;
    logic [THR_W-1:0]         i_cfg_data   = '0;

    // shadow of the block state and registers
    logic                     rule_q       = RULE_METROPOLIS;
    logic [RING_W-1:0]        ring_len_q   = RING_LEN_RST;
    logic [THR_W-1:0]         thr_q [NUM_THR];
    logic                     spin_q [RING_DEPTH];
    logic [CNT_W-1:0]         accepted_q   = '0;
    logic [CNT_W-1:0]         attempted_q  = '0;

    t_spin_result             pending_results [$];
    t_spin_result             oldest_result;
    int                       mismatch_count = 0;
    int                       cycle_count    = 0;
    bit                       no_idle        = 1'b0;

    ising_ring_spin_update_top #(
        .MAX_SPINS(RING_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_site           (i_site),
        .i_spin_value     (i_spin_value),
        .i_random_u       (i_random_u),
        .o_done           (o_done),
        .o_new_spin       (o_new_spin),
        .o_changed        (o_changed),
        .o_magnetization  (o_magnetization),
        .o_bond_sum       (o_bond_sum),
        .o_accepted_count (o_accepted_count),
        .o_attempted_count(o_attempted_count),
        .o_bad_site       (o_bad_site),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("ising_ring_spin_update_top regression: fail");
            $finish;
        end
    end

    // ring length as the datapath uses it
    function automatic int active_length();
        int n;
        n = int'(ring_len_q);
        if (n < 2) n = 2;
        if (n > RING_DEPTH) n = RING_DEPTH;
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // spin update predictor, advances the shadow state by one item
    function automatic t_spin_result predict_spin_item(input logic [MODE_W-1:0] mode,
                                                       input logic [SITE_W-1:0] site,
                                                       input logic val,
                                                       input logic [RND_W-1:0] rnd);
        t_spin_result r;
        int len, left, right, ups, nb, mag, bond;
        logic cur, nxt, flip;
        logic [THR_W-1:0] thr;
        r   = '0;
        len = active_length();
        case (mode)
            MODE_LOAD, MODE_UPDATE: begin
                if (int'(site) >= len) begin
                    r.bad_site = 1'b1;
                end else if (mode == MODE_LOAD) begin
                    r.changed = (spin_q[site] != val);
                    spin_q[site] = val;
                    r.new_spin = val;
                end else begin
                    left  = (site == 0) ? len - 1 : int'(site) - 1;
                    right = (int'(site) + 1 == len) ? 0 : int'(site) + 1;
                    ups   = int'(spin_q[left]) + int'(spin_q[right]);
                    cur   = spin_q[site];
                    thr   = thr_q[(cur ? 0 : 3) + ups];
                    if (rule_q == RULE_METROPOLIS) begin
                        flip = (thr >= {1'b0, rnd});
                        nxt  = flip ? ~cur : cur;
                        if (flip) accepted_q = sat_inc(accepted_q);
                        attempted_q = sat_inc(attempted_q);
                    end else begin
                        nxt = (thr > {1'b0, rnd});
                    end
                    r.changed = (nxt != cur);
                    spin_q[site] = nxt;
                    r.new_spin = nxt;
                end
            end
            MODE_MEASURE: begin
                mag  = 0;
                bond = 0;
                for (int i = 0; i < len; i++) begin
                    nb   = (i + 1 == len) ? 0 : i + 1;
                    mag  += spin_q[i] ? 1 : -1;
                    bond += (spin_q[i] == spin_q[nb]) ? 1 : -1;
                end
                r.magnetization = MEAS_W'(mag);
                r.bond_sum      = MEAS_W'(bond);
            end
            default: begin
                accepted_q  = '0;
                attempted_q = '0;
            end
        endcase
        r.accepted_count  = accepted_q;
        r.attempted_count = attempted_q;
        return r;
    endfunction

    // idle length before a beat: mostly none, some short, a few long
    function automatic int pick_gap();
        int pick;
        if (no_idle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return '0;
        if (pick < 40) return THR_ONE;
        if (pick < 50) return THR_W'($urandom_range(65537, 131071));
        return THR_W'($urandom_range(0, 65536));
    endfunction

    // random value, often sitting exactly on a threshold
    function automatic logic [RND_W-1:0] pick_random_u();
        int pick;
        logic [THR_W-1:0] thr;
        pick = $urandom_range(0, 99);
        thr  = thr_q[$urandom_range(0, NUM_THR - 1)];
        if (pick < 15) return thr[RND_W-1:0];
        if (pick < 20) return '0;
        if (pick < 25) return '1;
        return RND_W'($urandom);
    endfunction

    // send one item beat and record its expected result
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SITE_W-1:0] site,
                             input logic val, input logic [RND_W-1:0] rnd);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_mode       <= mode;
        i_site       <= site;
        i_spin_value <= val;
        i_random_u   <= rnd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_spin_item(mode, site, val, rnd));
    endtask

    // stop sending and wait for every expected result
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // one register write beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RULE:     rule_q = data[0];
            CFG_RING_LEN: ring_len_q = data[RING_W-1:0];
            default:      thr_q[idx - CFG_THR_BASE] = data;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want_v,
                               input logic [CNT_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want_v,
                     got_v);
            mismatch_count++;
        end
    endtask

    // result checker, one beat per strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("new_spin", oldest_result.new_spin, o_new_spin);
                check_field("changed", oldest_result.changed, o_changed);
                check_field("magnetization", oldest_result.magnetization,
                            $unsigned(o_magnetization));
                check_field("bond_sum", oldest_result.bond_sum, $unsigned(o_bond_sum));
                check_field("accepted_count", oldest_result.accepted_count, o_accepted_count);
                check_field("attempted_count", oldest_result.attempted_count,
                            o_attempted_count);
                check_field("bad_site", oldest_result.bad_site, o_bad_site);
            end
        end
    end

    // ring straight out of reset, all up
    task automatic test_reset_contents();
        send_item(MODE_MEASURE, '0, 1'b0, '0);
        send_item(MODE_UPDATE, '0, 1'b0, '1);
        send_item(MODE_LOAD, '1, 1'b0, '0);
        send_item(MODE_LOAD, '1, 1'b0, '1);
    endtask

    // sites outside the ring, wrap-around and clamped lengths
    task automatic test_ring_bounds();
        wait_drained();
        write_reg(CFG_RING_LEN, THR_W'(5));
        send_item(MODE_LOAD, SITE_W'(5), 1'b1, '0);
        send_item(MODE_UPDATE, '1, 1'b0, '0);
        send_item(MODE_LOAD, SITE_W'(4), 1'b0, '1);
        send_item(MODE_UPDATE, SITE_W'(4), 1'b1, 16'h8000);
        send_item(MODE_MEASURE, '0, 1'b0, '0);
        // zero acts as a two-site ring
        wait_drained();
        write_reg(CFG_RING_LEN, THR_W'(0));
        send_item(MODE_LOAD, SITE_W'(2), 1'b1, '0);
        send_item(MODE_UPDATE, SITE_W'(1), 1'b0, 16'h0001);
        // oversize length with junk above the field acts as the full ring
        wait_drained();
        write_reg(CFG_RING_LEN, {6'h3F, 11'h7FF});
        send_item(MODE_UPDATE, '1, 1'b1, 16'h0001);
    endtask

    // metropolis acceptance at and around the thresholds
    task automatic test_metropolis_rule();
        wait_drained();
        write_reg(CFG_RULE, THR_W'(RULE_METROPOLIS));
        write_reg(CFG_RING_LEN, THR_W'(3));
        write_reg(CFG_IDX_W'(CFG_THR_BASE + 0), THR_W'(0));
        write_reg(CFG_IDX_W'(CFG_THR_BASE + 1), 17'h1FFFF);
        write_reg(CFG_IDX_W'(CFG_THR_BASE + 2), THR_W'(12345));
        write_reg(CFG_IDX_W'(CFG_THR_BASE + 3), THR_ONE);
        write_reg(CFG_IDX_W'(CFG_THR_BASE + 4), THR_W'(0));
        write_reg(CFG_IDX_W'(CFG_THR_BASE + 5), THR_W'(1));
        send_item(MODE_CLEAR, '1, 1'b1, '1);
        send_item(MODE_LOAD, SITE_W'(0), 1'b1, '0);
        send_item(MODE_LOAD, SITE_W'(1), 1'b1, '0);
        send_item(MODE_LOAD, SITE_W'(2), 1'b1, '0);
        send_item(MODE_UPDATE, SITE_W'(1), 1'b0, RND_W'(12345));
        send_item(MODE_UPDATE, SITE_W'(1), 1'b0, RND_W'(12346));
        send_item(MODE_UPDATE, SITE_W'(0), 1'b0, '1);
    endtask

    // gibbs assignment on a two-site ring, counters frozen
    task automatic test_gibbs_two_site();
        wait_drained();
        write_reg(CFG_RULE, 17'h1FFFF);
        write_reg(CFG_RING_LEN, THR_W'(2));
        send_item(MODE_UPDATE, SITE_W'(0), 1'b0, '1);
        send_item(MODE_UPDATE, SITE_W'(1), 1'b0, RND_W'(1));
        send_item(MODE_MEASURE, '0, 1'b1, '1);
        send_item(MODE_CLEAR, '0, 1'b0, '0);
    endtask

    // random phases, each with fresh registers
    task automatic test_random_phases();
        int phase, item, pick, n, len;
        logic [MODE_W-1:0] mode;
        logic [SITE_W-1:0] site;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_drained();
            no_idle = (phase == 3) || (phase == 8);
            pick = $urandom_range(0, 99);
            if (phase == PHASE_COUNT - 1) n = 2;
            else if (phase == PHASE_COUNT - 2) n = RING_DEPTH;
            else if (pick < 40) n = $urandom_range(2, 16);
            else if (pick < 65) n = $urandom_range(17, 100);
            else if (pick < 75) n = $urandom_range(101, 400);
            else if (pick < 83) n = $urandom_range(0, 1);
            else if (pick < 93) n = $urandom_range(1000, 1024);
            else n = $urandom_range(1025, 2047);
            write_reg(CFG_RULE, THR_W'($urandom));
            write_reg(CFG_RING_LEN, {6'($urandom), RING_W'(n)});
            for (int k = 0; k < NUM_THR; k++) begin
                write_reg(CFG_IDX_W'(CFG_THR_BASE + k), pick_threshold());
            end
            len = active_length();
            for (item = 0; item < PHASE_ITEMS; item++) begin
                // sender holds off until the block has caught up
                if (phase == 5 && item == PHASE_ITEMS / 2) wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 18) mode = MODE_LOAD;
                else if (pick < 84) mode = MODE_UPDATE;
                else if (pick < 95) begin
                    mode = (len > 300 && $urandom_range(0, 9) != 0) ? MODE_UPDATE
                                                                    : MODE_MEASURE;
                end else mode = MODE_CLEAR;
                if ($urandom_range(0, 9) == 0) site = SITE_W'($urandom);
                else site = SITE_W'($urandom_range(0, len - 1));
                send_item(mode, site, 1'($urandom), pick_random_u());
            end
        end
        no_idle = 1'b0;
    endtask

    // main sequence
    initial begin
        for (int i = 0; i < RING_DEPTH; i++) spin_q[i] = 1'b1;
        for (int k = 0; k < NUM_THR; k++) thr_q[k] = THR_ONE;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_contents();
        test_ring_bounds();
        test_metropolis_rule();
        test_gibbs_two_site();
        test_random_phases();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ising_ring_spin_update_top regression: pass");
        end else begin
            $display("ising_ring_spin_update_top regression: fail");
        end
        $finish;
    end

endmodule
